@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for writing clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is low.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/iou_pkg.sv @@
// ----------------------------------------------------------------------------
// Box IoU package
// Default widths shared by the top level and the port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package iou_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

endpackage

`default_nettype wire

@@ hdl/iou_front.sv @@
// ----------------------------------------------------------------------------
// Box IoU front end
// Four-stage pipeline: per-axis overlap, extents and areas, intersection
// area and area sum, then union and divisor setup for the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module iou_front #(
    parameter int COORD_BITS = 12,
    parameter int AREA_W     = 2 * COORD_BITS,
    parameter int UNI_W      = 2 * COORD_BITS + 1,
    parameter int SIDE_W     = 4 * COORD_BITS + 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [COORD_BITS-1:0] in_first_left,
    input  wire logic [COORD_BITS-1:0] in_first_top,
    input  wire logic [COORD_BITS-1:0] in_first_width,
    input  wire logic [COORD_BITS-1:0] in_first_height,
    input  wire logic [COORD_BITS-1:0] in_second_left,
    input  wire logic [COORD_BITS-1:0] in_second_top,
    input  wire logic [COORD_BITS-1:0] in_second_width,
    input  wire logic [COORD_BITS-1:0] in_second_height,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [UNI_W-1:0]           out_rem,
    output logic [UNI_W-1:0]           out_div,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int C = COORD_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1 registers.
    logic [C-1:0] lo_x_reg, lo_y_reg, lo_x_next, lo_y_next;
    logic [C:0]   hi_x_reg, hi_y_reg, hi_x_next, hi_y_next;
    logic [C-1:0] w1_reg, h1_reg, w2_reg, h2_reg;
    logic [C:0]   end1_x, end2_x, end1_y, end2_y;

    // Stage 2 registers.
    logic [C-1:0]      org_x2_reg, org_y2_reg, org_x_next, org_y_next;
    logic [C:0]        ext_x2_reg, ext_y2_reg, ext_x_next, ext_y_next;
    logic [AREA_W-1:0] area1_reg, area2_reg, area1_next, area2_next;

    // Stage 3 registers.
    logic [C-1:0]      org_x3_reg, org_y3_reg;
    logic [C:0]        ext_x3_reg, ext_y3_reg;
    logic [AREA_W-1:0] inter_reg, inter_next;
    logic [UNI_W-1:0]  asum_reg, asum_next;
    logic [2*C+1:0]    inter_prod;

    // Stage 4 registers.
    logic [UNI_W-1:0]  rem_reg, div_reg, rem_next, div_next, union_area;
    logic [SIDE_W-1:0] side_reg, side_next;
    logic              empty;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        end1_x    = {1'b0, in_first_left} + {1'b0, in_first_width};
        end2_x    = {1'b0, in_second_left} + {1'b0, in_second_width};
        end1_y    = {1'b0, in_first_top} + {1'b0, in_first_height};
        end2_y    = {1'b0, in_second_top} + {1'b0, in_second_height};
        lo_x_next = (in_first_left > in_second_left) ? in_first_left : in_second_left;
        lo_y_next = (in_first_top > in_second_top) ? in_first_top : in_second_top;
        hi_x_next = (end1_x < end2_x) ? end1_x : end2_x;
        hi_y_next = (end1_y < end2_y) ? end1_y : end2_y;
    end

    always_comb begin
        if (hi_x_reg < {1'b0, lo_x_reg}) begin
            org_x_next = '0;
            ext_x_next = '0;
        end else begin
            org_x_next = lo_x_reg;
            ext_x_next = hi_x_reg - {1'b0, lo_x_reg};
        end
        if (hi_y_reg < {1'b0, lo_y_reg}) begin
            org_y_next = '0;
            ext_y_next = '0;
        end else begin
            org_y_next = lo_y_reg;
            ext_y_next = hi_y_reg - {1'b0, lo_y_reg};
        end
        area1_next = {{C{1'b0}}, w1_reg} * {{C{1'b0}}, h1_reg};
        area2_next = {{C{1'b0}}, w2_reg} * {{C{1'b0}}, h2_reg};
    end

    always_comb begin
        inter_prod = {{(C+1){1'b0}}, ext_x2_reg} * {{(C+1){1'b0}}, ext_y2_reg};
        inter_next = inter_prod[AREA_W-1:0];
        asum_next  = {1'b0, area1_reg} + {1'b0, area2_reg};
    end

    // An empty union forces a divisor of one with a zero remainder, so the
    // divider chain yields a zero ratio.
    always_comb begin
        union_area = asum_reg - {1'b0, inter_reg};
        empty      = (union_area == '0);
        div_next   = empty ? UNI_W'(1) : union_area;
        rem_next   = {1'b0, inter_reg};
        side_next  = {org_x3_reg, org_y3_reg, ext_x3_reg, ext_y3_reg, empty};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            lo_x_reg <= lo_x_next;
            lo_y_reg <= lo_y_next;
            hi_x_reg <= hi_x_next;
            hi_y_reg <= hi_y_next;
            w1_reg   <= in_first_width;
            h1_reg   <= in_first_height;
            w2_reg   <= in_second_width;
            h2_reg   <= in_second_height;
        end
        if (rdy2 && v1_reg) begin
            org_x2_reg <= org_x_next;
            org_y2_reg <= org_y_next;
            ext_x2_reg <= ext_x_next;
            ext_y2_reg <= ext_y_next;
            area1_reg  <= area1_next;
            area2_reg  <= area2_next;
        end
        if (rdy3 && v2_reg) begin
            org_x3_reg <= org_x2_reg;
            org_y3_reg <= org_y2_reg;
            ext_x3_reg <= ext_x2_reg;
            ext_y3_reg <= ext_y2_reg;
            inter_reg  <= inter_next;
            asum_reg   <= asum_next;
        end
        if (rdy4 && v3_reg) begin
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

@@ hdl/iou_div_cell.sv @@
// ----------------------------------------------------------------------------
// Box IoU divider cell
// One restoring-division step: resolves one quotient bit and hands the
// partial remainder, divisor, quotient and side data to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module iou_div_cell #(
    parameter int UNI_W  = 25,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 51,
    parameter bit DOUBLE = 1'b1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [UNI_W-1:0]  in_rem,
    input  wire logic [UNI_W-1:0]  in_div,
    input  wire logic [Q_W-1:0]    in_quo,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [UNI_W-1:0]       out_rem,
    output logic [UNI_W-1:0]       out_div,
    output logic [Q_W-1:0]         out_quo,
    output logic [SIDE_W-1:0]      out_side
);

    logic              valid_reg;
    logic [UNI_W-1:0]  rem_reg, div_reg, rem_next;
    logic [Q_W-1:0]    quo_reg, quo_next;
    logic [SIDE_W-1:0] side_reg;
    logic [UNI_W:0]    trial, diff;
    logic              take;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        trial    = DOUBLE ? {in_rem, 1'b0} : {1'b0, in_rem};
        diff     = trial - {1'b0, in_div};
        take     = (trial >= {1'b0, in_div});
        rem_next = take ? diff[UNI_W-1:0] : trial[UNI_W-1:0];
        quo_next = {in_quo[Q_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

@@ hdl/box_intersection_over_union.sv @@
// ----------------------------------------------------------------------------
// Box intersection over union
// Intersection box and IoU ratio of two axis-aligned boxes.
// ----------------------------------------------------------------------------
// The block takes one box pair per cycle while s_ready is high and returns
// one result per pair, in order. Four front stages find the overlap, the
// areas and the union; a chain of FRAC_BITS + 1 divider cells then resolves
// one ratio bit each, and the throughput is one transfer per cycle when the
// result side is ready. Stalls propagate stage by stage, so empty stages
// keep filling while a result waits. The ratio is truncated and reads zero,
// with empty_union set, when both boxes have zero area.
// ----------------------------------------------------------------------------
`default_nettype none

module box_intersection_over_union #(
    parameter int COORD_BITS = iou_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = iou_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COORD_BITS-1:0] s_first_left,
    input  wire logic [COORD_BITS-1:0] s_first_top,
    input  wire logic [COORD_BITS-1:0] s_first_width,
    input  wire logic [COORD_BITS-1:0] s_first_height,
    input  wire logic [COORD_BITS-1:0] s_second_left,
    input  wire logic [COORD_BITS-1:0] s_second_top,
    input  wire logic [COORD_BITS-1:0] s_second_width,
    input  wire logic [COORD_BITS-1:0] s_second_height,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [COORD_BITS-1:0]      m_overlap_left,
    output logic [COORD_BITS-1:0]      m_overlap_top,
    output logic [COORD_BITS:0]        m_overlap_width,
    output logic [COORD_BITS:0]        m_overlap_height,
    output logic [FRAC_BITS:0]         m_iou_ratio,
    output logic                       m_empty_union
);

    localparam int C      = COORD_BITS;
    localparam int AREA_W = 2 * C;
    localparam int UNI_W  = 2 * C + 1;
    localparam int SIDE_W = 4 * C + 3;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int NCELL  = FRAC_BITS + 1;

    logic              valid_w [0:NCELL];
    logic              ready_w [0:NCELL];
    logic [UNI_W-1:0]  rem_w   [0:NCELL];
    logic [UNI_W-1:0]  div_w   [0:NCELL];
    logic [Q_W-1:0]    quo_w   [0:NCELL];
    logic [SIDE_W-1:0] side_w  [0:NCELL];

    iou_front #(
        .COORD_BITS (C),
        .AREA_W     (AREA_W),
        .UNI_W      (UNI_W),
        .SIDE_W     (SIDE_W)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .in_first_left    (s_first_left),
        .in_first_top     (s_first_top),
        .in_first_width   (s_first_width),
        .in_first_height  (s_first_height),
        .in_second_left   (s_second_left),
        .in_second_top    (s_second_top),
        .in_second_width  (s_second_width),
        .in_second_height (s_second_height),
        .out_valid        (valid_w[0]),
        .out_ready        (ready_w[0]),
        .out_rem          (rem_w[0]),
        .out_div          (div_w[0]),
        .out_side         (side_w[0])
    );

    assign quo_w[0] = '0;

    // The first cell decides the integer bit without doubling the remainder.
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        iou_div_cell #(
            .UNI_W  (UNI_W),
            .Q_W    (Q_W),
            .SIDE_W (SIDE_W),
            .DOUBLE (i != 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_rem    (rem_w[i]),
            .in_div    (div_w[i]),
            .in_quo    (quo_w[i]),
            .in_side   (side_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_div   (div_w[i+1]),
            .out_quo   (quo_w[i+1]),
            .out_side  (side_w[i+1])
        );
    end

    assign ready_w[NCELL] = m_ready;
    assign m_valid        = valid_w[NCELL];
    assign m_iou_ratio    = quo_w[NCELL];

    assign m_overlap_left   = side_w[NCELL][SIDE_W-1 -: C];
    assign m_overlap_top    = side_w[NCELL][SIDE_W-1-C -: C];
    assign m_overlap_width  = side_w[NCELL][C+2 +: C+1];
    assign m_overlap_height = side_w[NCELL][1 +: C+1];
    assign m_empty_union    = side_w[NCELL][0];

endmodule

`default_nettype wire

@@ hdl/iou_checker.sv @@
// ----------------------------------------------------------------------------
// Box IoU port checker
// Watches the result port of the IoU block for reset, stall and value rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iou_checker #(
    parameter int COORD_BITS = iou_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = iou_pkg::FRAC_BITS_DEF
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [COORD_BITS:0]   m_overlap_width,
    input wire logic [FRAC_BITS:0]    m_iou_ratio,
    input wire logic                  m_empty_union
);

    `ASSERT_CLK(a_reset_idle, aclk, $past(!aresetn) |-> !m_valid, "result valid after reset")

    `ASSERT_CLKD(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_iou_ratio), "stalled result changed")

    `ASSERT_CLKD(a_empty_zero, aclk, aresetn, m_valid && m_empty_union |-> m_iou_ratio == '0, "empty union with nonzero ratio")

    `ASSERT_CLKD(a_ratio_max, aclk, aresetn, m_valid && m_iou_ratio[FRAC_BITS] |-> m_iou_ratio[FRAC_BITS-1:0] == '0, "ratio above one")

    `ASSERT_CLKD(a_no_overlap, aclk, aresetn, m_valid && m_overlap_width == '0 |-> m_iou_ratio == '0, "ratio without overlap")

endmodule

bind box_intersection_over_union iou_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_iou_checker (.*);

`default_nettype wire
